@@ rtl/dirty_range_tracker_defines.svh @@
// assertion macros for the dirty range tracker
`ifndef DIRTY_RANGE_TRACKER_DEFINES_SVH
`define DIRTY_RANGE_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
`define DRT_ASSERT_IMP(lbl, ck, rs, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rs) (ante) |-> (cons)) \
        else $error("dirty range tracker assertion failed");
`define DRT_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rs) (ante) |=> (cons)) \
        else $error("dirty range tracker assertion failed");
`else
`define DRT_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define DRT_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif

`endif

@@ rtl/drt_pkg.sv @@
// shared constants and types for the dirty range tracker
package drt_pkg;

    localparam int MAX_RANGES = 16;
    localparam int ADDR_BITS  = 24;
    localparam int LEN_W      = ADDR_BITS + 1;
    localparam int END_W      = ADDR_BITS + 2;
    localparam int IDX_W      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);

    localparam logic [1:0] LOCK_PLAIN        = 2'd0;
    localparam logic [1:0] LOCK_DISCARD      = 2'd1;
    localparam logic [1:0] LOCK_NO_OVERWRITE = 2'd2;

    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [LEN_W-1:0]     length;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } mem_wr_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } mem_rd_t;

endpackage

@@ rtl/drt_range_mem.sv @@
// range table memory, one write port and one registered read port
module drt_range_mem (
    input  logic             clk,
    input  drt_pkg::mem_wr_t wr,
    input  drt_pkg::mem_rd_t rd,
    output drt_pkg::entry_t  rd_data
);
    import drt_pkg::*;

    entry_t mem [MAX_RANGES];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

@@ rtl/drt_ctrl.sv @@
// scan sequencer, overlap test, table update and result register
`include "dirty_range_tracker_defines.svh"

module drt_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [drt_pkg::ADDR_BITS-1:0]  write_start,
    input  logic [drt_pkg::ADDR_BITS-1:0]  write_length,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           dirtied,
    output logic [1:0]                     lock_mode,
    output logic                           table_overflow,
    output drt_pkg::mem_wr_t               mem_wr,
    output drt_pkg::mem_rd_t               mem_rd,
    input  drt_pkg::entry_t                rd_data
);
    import drt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 dirty_reg;
    logic                 linked_reg;
    logic                 lock_dynamic_reg;
    logic                 out_valid_reg;
    logic                 dirty_out_reg;
    logic                 ovf_out_reg;
    logic [1:0]           lock_out_reg;
    logic [IDX_W-1:0]     link_idx_reg;
    entry_t               link_entry_reg;
    logic [ADDR_BITS-1:0] start_reg;
    logic [ADDR_BITS-1:0] len_reg;
    logic [LEN_W-1:0]     fin_reg;

    logic [END_W-1:0]     s_ext, e_ext, o_ext, f_ext;
    logic                 hit_ov, hit_link, scan_last, slot_free, full;
    logic                 overflow, clear, accept, commit;

    assign accept    = (state_reg == ST_IDLE) && in_valid;
    assign slot_free = !out_valid_reg || out_ready;
    assign commit    = (state_reg == ST_UPDATE) && slot_free;
    assign full      = (count_reg == CNT_W'(MAX_RANGES));
    assign overflow  = !dirty_reg && !linked_reg && full;
    assign clear     = dirty_reg || overflow;
    assign scan_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    always_comb
    begin
        s_ext    = END_W'(rd_data.start);
        e_ext    = END_W'(rd_data.start) + END_W'(rd_data.length);
        o_ext    = END_W'(start_reg);
        f_ext    = END_W'(fin_reg);
        hit_ov   = (s_ext <= o_ext && o_ext < e_ext) || (s_ext < f_ext && f_ext <= e_ext) ||
                   (o_ext <= s_ext && s_ext < f_ext) || (o_ext < e_ext && e_ext <= f_ext);
        hit_link = (o_ext == e_ext);
    end

    // next entry read goes out while the current one is tested
    always_comb
    begin
        mem_rd.en   = 1'b0;
        mem_rd.addr = '0;
        if (accept && count_reg != '0)
        begin
            mem_rd.en = 1'b1;
        end
        else if (state_reg == ST_SCAN && !hit_ov && !scan_last)
        begin
            mem_rd.en   = 1'b1;
            mem_rd.addr = idx_reg + IDX_W'(1);
        end
    end

    always_comb
    begin
        mem_wr.en = commit;
        if (clear)
        begin
            mem_wr.addr = '0;
            mem_wr.data = '{start: start_reg, length: LEN_W'(len_reg)};
        end
        else if (linked_reg)
        begin
            mem_wr.addr = link_idx_reg;
            mem_wr.data = '{start: link_entry_reg.start,
                            length: link_entry_reg.length + LEN_W'(len_reg)};
        end
        else
        begin
            mem_wr.addr = count_reg[IDX_W-1:0];
            mem_wr.data = '{start: start_reg, length: LEN_W'(len_reg)};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (count_reg != '0) ? ST_SCAN : ST_UPDATE;
                end
            end
            ST_SCAN:
            begin
                if (hit_ov || scan_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            idx_reg          <= '0;
            dirty_reg        <= 1'b0;
            linked_reg       <= 1'b0;
            lock_dynamic_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                lock_dynamic_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                idx_reg    <= '0;
                dirty_reg  <= 1'b0;
                linked_reg <= 1'b0;
            end
            else if (state_reg == ST_SCAN)
            begin
                if (hit_ov)
                begin
                    dirty_reg <= 1'b1;
                end
                else
                begin
                    if (hit_link)
                    begin
                        linked_reg <= 1'b1;
                    end
                    if (!scan_last)
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
            end
            if (commit)
            begin
                if (clear)
                begin
                    count_reg <= CNT_W'(1);
                end
                else if (!linked_reg)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            start_reg <= write_start;
            len_reg   <= write_length;
            fin_reg   <= LEN_W'(write_start) + LEN_W'(write_length);
        end
        if (state_reg == ST_SCAN && !hit_ov && hit_link)
        begin
            link_idx_reg   <= idx_reg;
            link_entry_reg <= rd_data;
        end
        if (commit)
        begin
            dirty_out_reg <= clear;
            ovf_out_reg   <= overflow;
            if (!lock_dynamic_reg)
            begin
                lock_out_reg <= LOCK_PLAIN;
            end
            else
            begin
                lock_out_reg <= clear ? LOCK_DISCARD : LOCK_NO_OVERWRITE;
            end
        end
    end

    assign in_ready       = (state_reg == ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign dirtied        = dirty_out_reg;
    assign lock_mode      = lock_out_reg;
    assign table_overflow = ovf_out_reg;

    `DRT_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(MAX_RANGES))
    `DRT_ASSERT_NEXT(a_clear_single, clk, rst_n, commit && clear, count_reg == CNT_W'(1))
    `DRT_ASSERT_IMP(a_ovf_dirty, clk, rst_n, out_valid_reg && ovf_out_reg, dirty_out_reg)
    `DRT_ASSERT_IMP(a_scan_idx, clk, rst_n, state_reg == ST_SCAN, CNT_W'(idx_reg) < count_reg)

endmodule

@@ rtl/dirty_range_tracker.sv @@
// dirty range tracker top level
// one write is handled at a time: in_ready is high only in idle, after the previous result
// has been committed; the table scan tests one entry per cycle through the single read port
// and an overlap ends the scan early
// reset: range count, handshake state and lock_dynamic clear at once; table contents are
// left as they are and no clearing pass runs
module dirty_range_tracker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [drt_pkg::ADDR_BITS-1:0] write_start,
    input  logic [drt_pkg::ADDR_BITS-1:0] write_length,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          dirtied,
    output logic [1:0]                    lock_mode,
    output logic                          table_overflow
);
    import drt_pkg::*;

    mem_wr_t mem_wr;
    mem_rd_t mem_rd;
    entry_t  rd_data;

    drt_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .write_start    (write_start),
        .write_length   (write_length),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .dirtied        (dirtied),
        .lock_mode      (lock_mode),
        .table_overflow (table_overflow),
        .mem_wr         (mem_wr),
        .mem_rd         (mem_rd),
        .rd_data        (rd_data)
    );

    drt_range_mem u_mem (
        .clk     (clk),
        .wr      (mem_wr),
        .rd      (mem_rd),
        .rd_data (rd_data)
    );

endmodule

@@ tb/dirty_range_tracker_tb.sv @@
// self-checking testbench for the dirty range tracker, with a predictor and random handshakes
`timescale 1ns / 1ps

module dirty_range_tracker_tb;
    import drt_pkg::*;

    localparam int TBL_GEN        = 0;
    localparam int TBL_LIVE       = 1;
    localparam int RANDOM_WRITES  = 1600;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 2 * MAX_RANGES + 4;
    localparam int PRINT_CAP      = 100;

    typedef enum logic [1:0] {
        STEP_WRITE,
        STEP_CONFIG,
        STEP_DRAIN
    } step_kind_t;

    typedef struct packed {
        step_kind_t           kind;
        logic [ADDR_BITS-1:0] start;
        logic [ADDR_BITS-1:0] length;
        logic                 dyn;
        logic [4:0]           gap;
        logic                 calm;
    } step_t;

    typedef struct packed {
        logic       dirtied;
        logic [1:0] lock_mode;
        logic       table_overflow;
    } lock_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic                 cfg_wr_data = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [ADDR_BITS-1:0] write_start = '0;
    logic [ADDR_BITS-1:0] write_length = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 dirtied;
    logic [1:0]           lock_mode;
    logic                 table_overflow;

    // two copies of the range table: one steers the stimulus, one predicts the block
    logic [ADDR_BITS-1:0] span_start [0:1][0:MAX_RANGES-1];
    logic [LEN_W-1:0]     span_len   [0:1][0:MAX_RANGES-1];
    int                   span_count [0:1];

    step_t        pending_q [$];
    lock_result_t lock_expect_q [$];
    int           sent_cnt = 0;
    int           recv_cnt = 0;
    int           err_cnt = 0;
    int           n_writes = 0;
    int           quiet_cycles = 0;
    logic         dyn_live = 1'b0;
    logic         rx_calm = 1'b0;
    logic         phase_calm = 1'b0;

    step_t        head;
    int           gap_left = 0;
    logic         gap_armed = 1'b0;
    logic         vld_n;
    logic         cfg_en_n;
    int           stall_left = 0;
    logic         rdy_n;
    lock_result_t want;

    dirty_range_tracker u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .write_start    (write_start),
        .write_length   (write_length),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .dirtied        (dirtied),
        .lock_mode      (lock_mode),
        .table_overflow (table_overflow)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit spans_overlap(input logic [ADDR_BITS-1:0] s,
                                         input logic [LEN_W-1:0] len,
                                         input logic [ADDR_BITS-1:0] o,
                                         input logic [ADDR_BITS-1:0] wl);
        logic [END_W-1:0] s_x, e, o_x, f;
        s_x = END_W'(s);
        e   = s_x + END_W'(len);
        o_x = END_W'(o);
        f   = o_x + END_W'(wl);
        return (s_x <= o_x && o_x < e) || (s_x < f && f <= e) ||
               (o_x <= s_x && s_x < f) || (o_x < e && e <= f);
    endfunction

    function automatic lock_result_t track_write(input int sel, input logic dyn,
                                                 input logic [ADDR_BITS-1:0] o,
                                                 input logic [ADDR_BITS-1:0] wl);
        lock_result_t     r;
        logic             hit, linked;
        int               link, n;
        logic [END_W-1:0] e;
        hit    = 1'b0;
        linked = 1'b0;
        link   = 0;
        r      = '0;
        n      = span_count[sel];
        for (int i = 0; i < n && !hit; i++)
        begin
            e = {2'b00, span_start[sel][i]} + END_W'(span_len[sel][i]);
            if (spans_overlap(span_start[sel][i], span_len[sel][i], o, wl))
                hit = 1'b1;
            else if ({2'b00, o} == e)
            begin
                linked = 1'b1;
                link   = i;
            end
        end
        // table full: behaves as an overlap
        if (!hit && !linked && n >= MAX_RANGES)
        begin
            hit              = 1'b1;
            r.table_overflow = 1'b1;
        end
        if (hit)
        begin
            span_start[sel][0] = o;
            span_len[sel][0]   = LEN_W'(wl);
            span_count[sel]    = 1;
        end
        else if (linked)
            span_len[sel][link] = span_len[sel][link] + LEN_W'(wl);
        else
        begin
            span_start[sel][n] = o;
            span_len[sel][n]   = LEN_W'(wl);
            span_count[sel]    = n + 1;
        end
        r.dirtied   = hit;
        r.lock_mode = !dyn ? LOCK_PLAIN : (hit ? LOCK_DISCARD : LOCK_NO_OVERWRITE);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_v);
        err_cnt++;
        if (err_cnt <= PRINT_CAP)
            $display("[%0t] result %0d: %s got %0d expected %0d",
                     $time, recv_cnt, what, got, exp_v);
    endtask

    task automatic add_write(input logic [ADDR_BITS-1:0] o, input logic [ADDR_BITS-1:0] wl);
        step_t st;
        st.kind   = STEP_WRITE;
        st.start  = o;
        st.length = wl;
        st.dyn    = 1'b0;
        st.calm   = phase_calm;
        st.gap    = phase_calm ? 5'd0 : 5'($urandom_range(0, 18));
        pending_q.push_back(st);
        void'(track_write(TBL_GEN, 1'b0, o, wl));
        n_writes++;
    endtask

    task automatic add_control(input step_kind_t kind, input logic dyn);
        step_t st;
        st      = '0;
        st.kind = kind;
        st.dyn  = dyn;
        pending_q.push_back(st);
    endtask

    function automatic logic [ADDR_BITS-1:0] short_len();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return ADDR_BITS'($urandom);
            default: return ADDR_BITS'($urandom_range(1, 4096));
        endcase
    endfunction

    task automatic add_noise();
        logic [ADDR_BITS-1:0] o, wl;
        case ($urandom_range(0, 3))
            0: o = '0;
            1: o = '1;
            default: o = ADDR_BITS'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0: wl = '0;
            1: wl = '1;
            default: wl = ADDR_BITS'($urandom);
        endcase
        add_write(o, wl);
    endtask

    task automatic add_append();
        logic [ADDR_BITS-1:0] o, wl;
        logic [END_W-1:0]     e;
        bit                   ok;
        int                   tries;
        wl    = short_len();
        tries = 0;
        do
        begin
            o  = ADDR_BITS'($urandom);
            ok = 1'b1;
            for (int i = 0; i < span_count[TBL_GEN]; i++)
            begin
                e = {2'b00, span_start[TBL_GEN][i]} + END_W'(span_len[TBL_GEN][i]);
                if (spans_overlap(span_start[TBL_GEN][i], span_len[TBL_GEN][i], o, wl) ||
                    {2'b00, o} == e)
                    ok = 1'b0;
            end
            tries++;
        end
        while (!ok && tries < 16);
        add_write(o, wl);
    endtask

    task automatic add_link();
        logic [END_W-1:0] e;
        int               i;
        if (span_count[TBL_GEN] == 0)
            add_append();
        else
        begin
            i = $urandom_range(0, span_count[TBL_GEN] - 1);
            e = {2'b00, span_start[TBL_GEN][i]} + END_W'(span_len[TBL_GEN][i]);
            if (e[END_W-1:ADDR_BITS] != 0)
                add_append();
            else
                add_write(e[ADDR_BITS-1:0], short_len());
        end
    endtask

    task automatic add_overlap();
        logic [ADDR_BITS-1:0] o;
        int                   i;
        if (span_count[TBL_GEN] == 0)
            add_noise();
        else
        begin
            i = $urandom_range(0, span_count[TBL_GEN] - 1);
            o = span_start[TBL_GEN][i];
            if (span_len[TBL_GEN][i] != 0)
                o = o + ADDR_BITS'($urandom_range(0, int'(span_len[TBL_GEN][i]) - 1));
            add_write(o, ADDR_BITS'($urandom_range(1, 256)));
        end
    endtask

    initial
    begin
        int   n, mode, pick;
        logic dyn;
        span_count[TBL_GEN]  = 0;
        span_count[TBL_LIVE] = 0;

        // directed: zero lengths, top of range, growth, overlap, full table
        add_control(STEP_CONFIG, 1'b1);
        add_write(24'h000000, 24'h000000);
        add_write(24'h000000, 24'h000000);
        add_write(24'hFFFFFF, 24'hFFFFFF);
        add_write(24'h000010, 24'h000020);
        add_write(24'h000030, 24'h000100);
        add_write(24'h000130, 24'hFF0000);
        add_write(24'h000020, 24'h000001);
        add_write(24'h000021, 24'h000000);
        for (int i = 0; i < MAX_RANGES; i++)
            add_write(24'h100000 + ADDR_BITS'(i) * 24'h001000, 24'h000010);

        dyn = 1'b1;
        while (n_writes < RANDOM_WRITES + 24)
        begin
            add_control(STEP_DRAIN, 1'b0);
            dyn = ~dyn;
            add_control(STEP_CONFIG, dyn);
            phase_calm = ($urandom_range(0, 3) == 0);
            repeat (8)
            begin
                mode = $urandom_range(0, 9);
                if (mode < 4)
                begin
                    n = $urandom_range(14, 20);
                    repeat (n)
                        if ($urandom_range(0, 99) < 85)
                            add_append();
                        else
                            add_link();
                end
                else if (mode < 8)
                begin
                    n = $urandom_range(8, 30);
                    repeat (n)
                    begin
                        pick = $urandom_range(0, 99);
                        if (pick < 40)
                            add_append();
                        else if (pick < 65)
                            add_link();
                        else if (pick < 80)
                            add_overlap();
                        else
                            add_noise();
                    end
                end
                else
                begin
                    n = $urandom_range(3, 10);
                    repeat (n)
                        add_noise();
                end
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // sampled mid-cycle so the driver's updates have settled
        while (pending_q.size() != 0 || in_valid || sent_cnt != recv_cnt)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sent_cnt != recv_cnt || lock_expect_q.size() != 0)
            report_mismatch("results received", recv_cnt, sent_cnt);
        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            write_start  <= '0;
            write_length <= '0;
            cfg_wr_en    <= 1'b0;
            cfg_wr_data  <= 1'b0;
            rx_calm      <= 1'b0;
            sent_cnt     <= 0;
            gap_left     = 0;
            gap_armed    = 1'b0;
            dyn_live     = 1'b0;
        end
        else
        begin
            vld_n    = in_valid;
            cfg_en_n = 1'b0;
            if (in_valid && in_ready)
            begin
                lock_expect_q.push_back(track_write(TBL_LIVE, dyn_live, write_start,
                                                    write_length));
                sent_cnt <= sent_cnt + 1;
                vld_n = 1'b0;
            end
            if (!vld_n && pending_q.size() > 0)
            begin
                head = pending_q[0];
                case (head.kind)
                    STEP_WRITE:
                    begin
                        if (!gap_armed)
                        begin
                            gap_left  = int'(head.gap);
                            gap_armed = 1'b1;
                        end
                        if (gap_left > 0)
                            gap_left--;
                        else
                        begin
                            void'(pending_q.pop_front());
                            gap_armed = 1'b0;
                            vld_n     = 1'b1;
                            write_start  <= head.start;
                            write_length <= head.length;
                            rx_calm      <= head.calm;
                        end
                    end
                    STEP_CONFIG:
                    begin
                        // only while idle: nothing in flight, nothing owed
                        if (!in_valid && sent_cnt == recv_cnt)
                        begin
                            void'(pending_q.pop_front());
                            cfg_en_n = 1'b1;
                            cfg_wr_data <= head.dyn;
                            dyn_live = head.dyn;
                        end
                    end
                    default:
                    begin
                        if (!in_valid && sent_cnt == recv_cnt)
                            void'(pending_q.pop_front());
                    end
                endcase
            end
            in_valid  <= vld_n;
            cfg_wr_en <= cfg_en_n;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            recv_cnt   <= 0;
            stall_left = 0;
        end
        else
        begin
            rdy_n = out_ready;
            if (out_valid && out_ready)
            begin
                if (recv_cnt == sent_cnt)
                    report_mismatch("unexpected transfer, dirtied", int'(dirtied), 0);
                else
                begin
                    want = lock_expect_q.pop_front();
                    if (dirtied !== want.dirtied)
                        report_mismatch("dirtied", int'(dirtied), int'(want.dirtied));
                    if (lock_mode !== want.lock_mode)
                        report_mismatch("lock_mode", int'(lock_mode), int'(want.lock_mode));
                    if (table_overflow !== want.table_overflow)
                        report_mismatch("table_overflow", int'(table_overflow),
                                        int'(want.table_overflow));
                    recv_cnt <= recv_cnt + 1;
                end
                stall_left = rx_calm ? 0 : $urandom_range(0, 18);
                rdy_n      = (stall_left == 0);
            end
            else if (!out_ready)
            begin
                if (stall_left > 0)
                    stall_left--;
                if (stall_left == 0)
                    rdy_n = 1'b1;
            end
            out_ready <= rdy_n;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/drt_pkg.sv
rtl/drt_range_mem.sv
rtl/drt_ctrl.sv
rtl/dirty_range_tracker.sv
tb/dirty_range_tracker_tb.sv
